### hw/rtl/circular_arc_activation_core_assert.svh
// assertion macros used by the checker file of the activation core
`ifndef CIRCULAR_ARC_ACTIVATION_CORE_ASSERT_SVH
`define CIRCULAR_ARC_ACTIVATION_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CAAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define CAAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/caac_pkg.sv
// types, constants and helper functions of the circular arc activation core
package caac_pkg;

    // sample format
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int UNS_WIDTH  = DATA_WIDTH - 1;

    // datapath widths
    localparam int MUL_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LIN_W      = PROD_W - FRAC_BITS + 1;
    localparam int RAD_W      = 2 * DATA_WIDTH;
    localparam int ROOT_W     = DATA_WIDTH;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int HALF       = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;

    // configuration port
    localparam int CFG_IDX_W  = 3;

    localparam logic [UNS_WIDTH-1:0]  KNEE_RESET  = UNS_WIDTH'(1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] SLOPE_RESET = DATA_WIDTH'(1 << FRAC_BITS);

    typedef logic signed [DATA_WIDTH-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAK_SLOPE,
        CFG_KNEE_POINT,
        CFG_CENTER_X,
        CFG_CENTER_Y_OFFSET,
        CFG_KNEE_OUTPUT,
        CFG_UPPER_SLOPE
    } cfg_index_t;

    typedef enum logic [1:0] {
        REGION_LEAK,
        REGION_ARC,
        REGION_LINE
    } region_t;

    // register file contents
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] leak_slope;
        logic        [UNS_WIDTH-1:0]  knee_point;
        logic signed [DATA_WIDTH-1:0] center_x;
        logic        [UNS_WIDTH-1:0]  center_y_offset;
        logic signed [DATA_WIDTH-1:0] knee_output;
        logic signed [DATA_WIDTH-1:0] upper_slope;
    } cfg_t;

    // side data that rides along the root chain
    typedef struct packed {
        region_t                 region;
        logic signed [LIN_W-1:0] lin;
    } side_t;

    // word handed from one root cell to the next
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } root_word_t;

    // clamp a wide signed value to the sample range
    function automatic sample_t saturate(input logic signed [LIN_W-1:0] v);
        logic signed [LIN_W-1:0] hi;
        logic signed [LIN_W-1:0] lo;
        sample_t                 res;
        hi = LIN_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
        lo = LIN_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));
        if (v > hi)
        begin
            res = hi[DATA_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            res = lo[DATA_WIDTH-1:0];
        end
        else
        begin
            res = v[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/caac_if.sv
// stream and configuration interfaces of the activation core
interface caac_in_if;
    import caac_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface caac_out_if;
    import caac_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface caac_cfg_if;
    import caac_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/caac_prep.sv
// front stages: region select, squares and products, radicand and linear value
module caac_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  caac_pkg::sample_t   sample_in,
    input  caac_pkg::cfg_t      cfg,
    output logic                out_valid,
    output caac_pkg::root_word_t out_word
);
    import caac_pkg::*;

    // stage a combinational
    logic signed [DATA_WIDTH:0]   x_ext;
    logic signed [DATA_WIDTH:0]   xc_ext;
    logic signed [DATA_WIDTH:0]   knee_ext;
    logic signed [DATA_WIDTH:0]   diff;
    logic signed [DATA_WIDTH:0]   over_knee;
    logic                         le_zero;
    logic                         le_knee;
    region_t                      region_a;
    logic [DATA_WIDTH-1:0]        ad_a;
    logic [DATA_WIDTH-1:0]        axc_a;
    logic signed [MUL_W-1:0]      mul_a_a;
    logic signed [MUL_W-1:0]      mul_b_a;

    // stage a registers
    logic                         valid_a_reg;
    region_t                      region_a_reg;
    logic [DATA_WIDTH-1:0]        ad_a_reg;
    logic [DATA_WIDTH-1:0]        axc_a_reg;
    logic signed [MUL_W-1:0]      mul_a_reg;
    logic signed [MUL_W-1:0]      mul_b_reg;

    // stage b registers
    logic                         valid_b_reg;
    region_t                      region_b_reg;
    logic [RAD_W-1:0]             sq_xc_reg;
    logic [RAD_W-3:0]             sq_yc_reg;
    logic [RAD_W-1:0]             sq_d_reg;
    logic signed [PROD_W-1:0]     prod_reg;

    // stage c
    logic signed [PROD_W-1:0]     prod_half;
    logic                         valid_c_reg;
    region_t                      region_c_reg;
    logic [RAD_W-1:0]             a_sum_reg;
    logic [RAD_W-1:0]             sq_d_c_reg;
    logic signed [LIN_W-2:0]      lin_round_reg;

    // stage d
    logic [RAD_W-1:0]             rad_d;
    logic signed [LIN_W-1:0]      knee_add;
    logic signed [LIN_W-1:0]      lin_d;
    logic                         valid_d_reg;
    root_word_t                   word_d_reg;

    // region decision and operand selection
    always_comb
    begin
        x_ext     = {sample_in[DATA_WIDTH-1], sample_in};
        xc_ext    = {cfg.center_x[DATA_WIDTH-1], cfg.center_x};
        knee_ext  = $signed({2'b00, cfg.knee_point});
        diff      = x_ext - xc_ext;
        over_knee = x_ext - knee_ext;
        le_zero   = sample_in[DATA_WIDTH-1] || (sample_in == '0);
        le_knee   = (x_ext <= knee_ext);
        if (le_zero)
        begin
            region_a = REGION_LEAK;
        end
        else if (le_knee)
        begin
            region_a = REGION_ARC;
        end
        else
        begin
            region_a = REGION_LINE;
        end
        ad_a  = diff[DATA_WIDTH] ? DATA_WIDTH'(-diff) : diff[DATA_WIDTH-1:0];
        axc_a = xc_ext[DATA_WIDTH] ? DATA_WIDTH'(-xc_ext) : xc_ext[DATA_WIDTH-1:0];
        if (region_a == REGION_LINE)
        begin
            mul_a_a = MUL_W'(cfg.upper_slope);
            mul_b_a = MUL_W'(over_knee);
        end
        else
        begin
            mul_a_a = MUL_W'(cfg.leak_slope);
            mul_b_a = MUL_W'(x_ext);
        end
    end

    // rounding of the slope product
    assign prod_half = prod_reg + PROD_W'(HALF);

    // radicand clamp and knee offset
    always_comb
    begin
        rad_d    = (a_sum_reg > sq_d_c_reg) ? (a_sum_reg - sq_d_c_reg) : '0;
        knee_add = (region_c_reg == REGION_LINE) ? LIN_W'(cfg.knee_output) : '0;
        lin_d    = LIN_W'(lin_round_reg) + knee_add;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            region_a_reg <= region_a;
            ad_a_reg     <= ad_a;
            axc_a_reg    <= axc_a;
            mul_a_reg    <= mul_a_a;
            mul_b_reg    <= mul_b_a;

            region_b_reg <= region_a_reg;
            sq_xc_reg    <= RAD_W'(axc_a_reg) * RAD_W'(axc_a_reg);
            sq_yc_reg    <= (RAD_W-2)'(cfg.center_y_offset) *
                            (RAD_W-2)'(cfg.center_y_offset);
            sq_d_reg     <= RAD_W'(ad_a_reg) * RAD_W'(ad_a_reg);
            prod_reg     <= PROD_W'(mul_a_reg) * PROD_W'(mul_b_reg);

            region_c_reg  <= region_b_reg;
            a_sum_reg     <= sq_xc_reg + RAD_W'(sq_yc_reg);
            sq_d_c_reg    <= sq_d_reg;
            lin_round_reg <= prod_half[PROD_W-1:FRAC_BITS];

            word_d_reg.rad         <= rad_d;
            word_d_reg.rem         <= '0;
            word_d_reg.root        <= '0;
            word_d_reg.side.region <= region_c_reg;
            word_d_reg.side.lin    <= lin_d;
        end
    end

    assign out_valid = valid_d_reg;
    assign out_word  = word_d_reg;

endmodule

### hw/rtl/caac_root_cell.sv
// one step of the digit-by-digit square root, two radicand bits per cell
module caac_root_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  caac_pkg::root_word_t in_word,
    output logic                 out_valid,
    output caac_pkg::root_word_t out_word
);
    import caac_pkg::*;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    root_word_t        word_next;
    logic              valid_reg;
    root_word_t        word_reg;

    // bring down two bits and try the next root digit
    always_comb
    begin
        rem_shift      = {in_word.rem[REM_W-3:0], in_word.rad[RAD_W-1:RAD_W-2]};
        trial          = {in_word.root, 2'b01};
        word_next      = in_word;
        word_next.rad  = {in_word.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial)
        begin
            word_next.rem  = rem_shift - trial;
            word_next.root = {in_word.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = rem_shift;
            word_next.root = {in_word.root[ROOT_W-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // hand the word to the next cell
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### hw/rtl/circular_arc_activation_core.sv
// Circular arc activation core: one Q8.8 sample in, one saturated Q8.8 sample out.
// Takes one word per clock and keeps taking them while results flow out. The pipeline is
// four front stages (region select, squares and slope product, sums, radicand clamp),
// a chain of ROOT_STEPS square root cells that each settle one root bit, and the
// output register. The whole pipeline halts while a finished word waits at the output,
// so ready follows "output register empty or being taken". Configuration writes are
// always taken and must only happen while no word is in flight.
module circular_arc_activation_core (
    input logic       clk,
    input logic       rst_n,
    caac_in_if.sink   act,
    caac_out_if.source res,
    caac_cfg_if.sink  cfg
);
    import caac_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       advance;

    logic       prep_valid;
    root_word_t prep_word;

    logic       chain_valid [ROOT_STEPS+1];
    root_word_t chain_word  [ROOT_STEPS+1];

    root_word_t                last_word;
    logic signed [ROOT_W:0]    arc_val;
    logic signed [LIN_W-1:0]   curve_val;
    sample_t                   result;

    logic       out_valid_reg;
    sample_t    out_data_reg;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEAK_SLOPE:      cfg_next.leak_slope      = cfg.data;
                CFG_KNEE_POINT:      cfg_next.knee_point      = cfg.data[UNS_WIDTH-1:0];
                CFG_CENTER_X:        cfg_next.center_x        = cfg.data;
                CFG_CENTER_Y_OFFSET: cfg_next.center_y_offset = cfg.data[UNS_WIDTH-1:0];
                CFG_KNEE_OUTPUT:     cfg_next.knee_output     = cfg.data;
                CFG_UPPER_SLOPE:     cfg_next.upper_slope     = cfg.data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leak_slope      <= '0;
            cfg_reg.knee_point      <= KNEE_RESET;
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y_offset <= '0;
            cfg_reg.knee_output     <= '0;
            cfg_reg.upper_slope     <= SLOPE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    // pipeline moves whenever the output register can take a word
    assign advance   = !out_valid_reg || res.ready;
    assign act.ready = advance;

    caac_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (act.valid),
        .sample_in (act.sample_in),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_word  (prep_word)
    );

    assign chain_valid[0] = prep_valid;
    assign chain_word[0]  = prep_word;

    // square root cell chain
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        caac_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    // pick the curve piece and saturate
    always_comb
    begin
        last_word = chain_word[ROOT_STEPS];
        arc_val   = $signed({1'b0, last_word.root}) -
                    $signed({2'b00, cfg_reg.center_y_offset});
        if (last_word.side.region == REGION_ARC)
        begin
            curve_val = LIN_W'(arc_val);
        end
        else
        begin
            curve_val = last_word.side.lin;
        end
        result = saturate(curve_val);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.sample_out = out_data_reg;

endmodule

### hw/rtl/caac_checker.sv
// port-level checks of the activation core and their binding
`include "circular_arc_activation_core_assert.svh"

module caac_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              act_ready,
    input logic              res_valid,
    input logic              res_ready,
    input caac_pkg::sample_t res_data,
    input logic              cfg_ready
);
    import caac_pkg::*;

    // a stalled result word stays offered
    `CAAC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result word dropped while stalled")

    // a stalled result word keeps its value
    `CAAC_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_data), "result word changed while stalled")

    // input is taken exactly when the output register frees up
    `CAAC_ASSERT_SAME(a_ready_link, clk, rst_n, 1'b1, act_ready == (!res_valid || res_ready), "input ready out of step with output")

    // register writes never stall
    `CAAC_ASSERT_SAME(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind circular_arc_activation_core caac_checker u_caac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .act_ready (act.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.sample_out),
    .cfg_ready (cfg.ready)
);

### test/caac_tb_pkg.sv
`timescale 1ns / 100ps
// scoreboard class holding the expected-value model of the activation core
package caac_tb_pkg;
    import caac_pkg::*;

    // register indexes past the defined set, the core drops writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

    class activation_scoreboard;
        logic signed [DATA_WIDTH-1:0] leak_slope;
        logic        [UNS_WIDTH-1:0]  knee_point;
        logic signed [DATA_WIDTH-1:0] center_x;
        logic        [UNS_WIDTH-1:0]  center_y_offset;
        logic signed [DATA_WIDTH-1:0] knee_output;
        logic signed [DATA_WIDTH-1:0] upper_slope;
        sample_t                      expected_q[$];
        int                           mismatches;

        function new();
            mismatches = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            leak_slope      = '0;
            knee_point      = KNEE_RESET;
            center_x        = '0;
            center_y_offset = '0;
            knee_output     = '0;
            upper_slope     = SLOPE_RESET;
        endfunction

        // mirror of the register file, narrow registers drop the top bit
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] value);
            case (idx)
                CFG_LEAK_SLOPE:      leak_slope      = value;
                CFG_KNEE_POINT:      knee_point      = value[UNS_WIDTH-1:0];
                CFG_CENTER_X:        center_x        = value;
                CFG_CENTER_Y_OFFSET: center_y_offset = value[UNS_WIDTH-1:0];
                CFG_KNEE_OUTPUT:     knee_output     = value;
                CFG_UPPER_SLOPE:     upper_slope     = value;
                default:             ;
            endcase
        endfunction

        // drop the extra fraction bits, rounding half up
        function longint round_q(longint v);
            return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        endfunction

        // floor of the square root, one bit at a time
        function longint int_sqrt(longint r);
            longint root;
            longint trial;
            root = 0;
            for (int b = DATA_WIDTH; b >= 0; b--)
            begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= r)
                begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function sample_t clamp(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                v = hi;
            end
            else if (v < lo)
            begin
                v = lo;
            end
            return sample_t'(v);
        endfunction

        // three-piece curve: leaky line, circular arc, upper line
        function sample_t curve_value(sample_t x);
            longint xv;
            longint knee;
            longint xc;
            longint yc;
            longint rad;
            longint y;
            xv   = x;
            knee = knee_point;
            xc   = center_x;
            yc   = center_y_offset;
            if (xv <= 0)
            begin
                y = round_q(longint'(leak_slope) * xv);
            end
            else if (xv <= knee)
            begin
                rad = xc * xc + yc * yc - (xv - xc) * (xv - xc);
                if (rad < 0)
                begin
                    rad = 0;
                end
                y = int_sqrt(rad) - yc;
            end
            else
            begin
                y = longint'(knee_output) + round_q((xv - knee) * longint'(upper_slope));
            end
            return clamp(y);
        endfunction

        function void note_sample(sample_t x);
            expected_q.insert(expected_q.size(), curve_value(x));
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, got %0d", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

### test/tb_circular_arc_activation_core.sv
`timescale 1ns / 100ps
// top-level testbench of the circular arc activation core
module tb_circular_arc_activation_core;
    import caac_pkg::*;
    import caac_tb_pkg::*;

    typedef enum {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    localparam int PHASES       = 10;
    localparam int CHUNKS       = 4;
    localparam int CHUNK_ITEMS  = 35;
    localparam int DRAIN_CYCLES = 30;
    localparam int TIMEOUT_NS   = 2000000;

    localparam sample_t SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam sample_t RESET_POINTS [7] =
        '{SAMPLE_MIN, -16'sd1, 16'sd0, 16'sd1, 16'sd256, 16'sd257, SAMPLE_MAX};
    localparam sample_t EXTREME_A_POINTS [4] = '{SAMPLE_MIN, 16'sd1, 16'sd128, SAMPLE_MAX};
    localparam sample_t EXTREME_B_POINTS [4] = '{SAMPLE_MIN, 16'sd0, 16'sd1, SAMPLE_MAX};

    logic                 clk;
    logic                 rst_n;
    int                   src_idle_pct;
    int                   sink_stall_pct;
    activation_scoreboard board;

    caac_in_if  act_if ();
    caac_out_if res_if ();
    caac_cfg_if cfg_if ();

    circular_arc_activation_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .act   (act_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SOURCE:
            begin
                src_idle_pct   = 61;
                sink_stall_pct = 0;
            end
            IDLE_SINK:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 61;
            end
            IDLE_BOTH:
            begin
                src_idle_pct   = 27;
                sink_stall_pct = 27;
            end
            default:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    // one register write word, valid stays up for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        board.write_reg(idx, value);
    endtask

    task automatic release_cfg();
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [DATA_WIDTH-1:0] leak,
                                input logic [DATA_WIDTH-1:0] knee,
                                input logic [DATA_WIDTH-1:0] cx,
                                input logic [DATA_WIDTH-1:0] cyo,
                                input logic [DATA_WIDTH-1:0] kout,
                                input logic [DATA_WIDTH-1:0] upper);
        write_register(CFG_LEAK_SLOPE, leak);
        write_register(CFG_KNEE_POINT, knee);
        write_register(CFG_CENTER_X, cx);
        write_register(CFG_CENTER_Y_OFFSET, cyo);
        write_register(CFG_KNEE_OUTPUT, kout);
        write_register(CFG_UPPER_SLOPE, upper);
        release_cfg();
    endtask

    // full-range value half the time, otherwise a value from a useful span
    function automatic logic [DATA_WIDTH-1:0] random_reg(input int lo, input int hi);
        if ($urandom_range(1) == 0)
        begin
            return DATA_WIDTH'($urandom());
        end
        return DATA_WIDTH'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic random_config();
        apply_config(random_reg(-256, 256), random_reg(0, 2048), random_reg(-1024, 2048),
                     random_reg(0, 1024), random_reg(-512, 1024), random_reg(-512, 512));
    endtask

    // input word, optionally preceded by idle cycles
    task automatic send_sample(input sample_t x);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            act_if.valid <= 1'b0;
            @(negedge clk);
        end
        act_if.valid     <= 1'b1;
        act_if.sample_in <= x;
        @(posedge clk);
        while (!act_if.ready)
        begin
            @(posedge clk);
        end
        board.note_sample(x);
    endtask

    task automatic end_stream();
        @(negedge clk);
        act_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // samples biased toward the arc and the knee, with extremes and noise
    function automatic sample_t random_sample();
        int      knee;
        sample_t x;
        knee = board.knee_point;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                x = (knee > 0) ? sample_t'($urandom_range(knee, 1)) : sample_t'($urandom());
            end
            4: x = sample_t'(knee + int'($urandom_range(8)) - 4);
            5, 6: x = sample_t'(int'($urandom_range(2047)) - 1024);
            7:
            begin
                case ($urandom_range(4))
                    0: x = SAMPLE_MIN;
                    1: x = SAMPLE_MAX;
                    2: x = 16'sd0;
                    3: x = 16'sd1;
                    default: x = -16'sd1;
                endcase
            end
            default: x = sample_t'($urandom());
        endcase
        return x;
    endfunction

    // receiver with random stalls
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            board.check_sample(res_if.sample_out);
        end
    end

    // stimulus
    initial
    begin
        board            = new();
        rst_n            = 1'b0;
        act_if.valid     = 1'b0;
        act_if.sample_in = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        set_idle_mode(IDLE_NONE);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register values after reset
        foreach (RESET_POINTS[i])
        begin
            send_sample(RESET_POINTS[i]);
        end
        end_stream();
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_config(16'sd26, 16'sd256, 16'sd512, 16'sd128, 16'sd333, 16'sd256);
                1:
                begin
                    // saturation on the leaky side, negative radicand on the arc
                    apply_config(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                                 SAMPLE_MAX, SAMPLE_MIN);
                    foreach (EXTREME_A_POINTS[i])
                    begin
                        send_sample(EXTREME_A_POINTS[i]);
                    end
                end
                2:
                begin
                    // zero knee, so every positive sample is on the upper line
                    apply_config(SAMPLE_MAX, '0, SAMPLE_MAX, '0, SAMPLE_MIN, SAMPLE_MAX);
                    foreach (EXTREME_B_POINTS[i])
                    begin
                        send_sample(EXTREME_B_POINTS[i]);
                    end
                end
                3:
                begin
                    // writes to spare indexes and the top knee bit must have no effect
                    random_config();
                    write_register(CFG_SPARE_LO, DATA_WIDTH'($urandom()));
                    write_register(CFG_SPARE_HI, DATA_WIDTH'($urandom()));
                    write_register(CFG_KNEE_POINT, {1'b1, board.knee_point});
                    release_cfg();
                end
                default: random_config();
            endcase

            for (int chunk = 0; chunk < CHUNKS; chunk++)
            begin
                set_idle_mode(idle_mode_t'((phase + chunk) % CHUNKS));
                repeat (CHUNK_ITEMS) send_sample(random_sample());
            end
            end_stream();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // timeout
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
